FILE: rtl/lch_pkg.sv
// ----------------------------------------------------------------------------
// lch_pkg
// shared constants, codes and types of the layer color histogram
// ----------------------------------------------------------------------------
`default_nettype none

package lch_pkg;

    localparam int COUNT_W     = 24;
    localparam int LEVEL_CH    = 10;
    localparam int LEVEL_BINS  = 256;
    localparam int HUE_BINS    = 360;
    localparam int LEVEL_DEPTH = LEVEL_CH * LEVEL_BINS;
    localparam int LEVEL_AW    = $clog2(LEVEL_DEPTH);
    localparam int HUE_AW      = $clog2(HUE_BINS);
    localparam int DIV_W       = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [15:0] W_RED   = 16'd19589;
    localparam logic [15:0] W_GREEN = 16'd38445;
    localparam logic [15:0] W_BLUE  = 16'd7502;

    typedef enum logic [1:0] {
        CMD_COUNT    = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_READ_BIN = 2'd2,
        CMD_READ_EXT = 2'd3
    } cmd_t;

    localparam logic [3:0] CH_ALPHA = 4'd3;
    localparam logic [3:0] CH_HUE   = 4'd4;
    localparam logic [3:0] CH_LAST  = 4'd10;
    localparam logic [3:0] LV_ALPHA = 4'd3;
    localparam logic [3:0] LV_LAST  = 4'd9;

    // divider operations of the pixel sequencer
    localparam logic [3:0] OP_RED   = 4'd0;
    localparam logic [3:0] OP_GREEN = 4'd1;
    localparam logic [3:0] OP_BLUE  = 4'd2;
    localparam logic [3:0] OP_SAT   = 4'd3;
    localparam logic [3:0] OP_LUMA  = 4'd4;
    localparam logic [3:0] OP_CYAN  = 4'd5;
    localparam logic [3:0] OP_MAG   = 4'd6;
    localparam logic [3:0] OP_YEL   = 4'd7;
    localparam logic [3:0] OP_KEY   = 4'd8;
    localparam logic [3:0] OP_HUE   = 4'd9;

    typedef struct packed {
        cmd_t                     cmd;
        logic [3:0]               channel;
        logic [8:0]               bin;
        logic [LEVEL_CH-1:0][7:0] lv;
        logic [HUE_AW-1:0]        hue;
    } lch_job_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lch_ram.sv
// ----------------------------------------------------------------------------
// lch_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lch_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

FILE: rtl/lch_div.sv
// ----------------------------------------------------------------------------
// lch_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lch_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [lch_pkg::DIV_W-1:0] dividend,
    input  wire logic [7:0]               divisor,
    output logic                          done,
    output logic      [lch_pkg::DIV_W-1:0] quotient
);
    import lch_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [7:0]       rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [8:0]       sh;
    logic             ge;

    assign sh       = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = sh >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W - 1);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? 8'(sh - {1'b0, dvs_reg}) : sh[7:0];
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end
endmodule

`default_nettype wire

FILE: rtl/lch_front.sv
// ----------------------------------------------------------------------------
// lch_front
// accepts transactions and works out the eleven bins of a pixel
// ----------------------------------------------------------------------------
`default_nettype none

module lch_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              selection_enable,
    input  wire logic              hold,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_cmd,
    input  wire logic [7:0]        s_red,
    input  wire logic [7:0]        s_green,
    input  wire logic [7:0]        s_blue,
    input  wire logic [7:0]        s_alpha,
    input  wire logic [7:0]        s_selection,
    input  wire logic [3:0]        s_channel,
    input  wire logic [8:0]        s_bin,
    output logic                   job_push,
    input  wire logic              job_full,
    output lch_pkg::lch_job_t      job
);
    import lch_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_PREP1 = 6'b000010,
        F_PREP2 = 6'b000100,
        F_START = 6'b001000,
        F_WAIT  = 6'b010000,
        F_PUSH  = 6'b100000
    } front_state_t;

    front_state_t             state_reg, state_next;
    cmd_t                     cmd_reg;
    logic [3:0]               ch_reg;
    logic [8:0]               bin_reg;
    logic [7:0]               r_reg, g_reg, b_reg, alpha_reg, sel_reg;
    logic [7:0]               a_reg, mx_reg, mn_reg, luma_reg, d_reg;
    logic [1:0]               which_reg;
    logic [7:0]               c_reg, m_reg, y_reg, k_reg;
    logic [DIV_W-1:0]         num_reg;
    logic [3:0]               op_reg;
    logic [LEVEL_CH-1:0][7:0] lv_reg;
    logic [HUE_AW-1:0]        hue_reg;

    logic [15:0]      sel_prod;
    logic [16:0]      sel_sum;
    logic [7:0]       a_val, mx_val, mn_val;
    logic [1:0]       which_val;
    logic [23:0]      luma_sum;
    logic signed [19:0] diff_s, base_s, num_s, d_s;
    logic [7:0]       x_val, dvs;
    logic [DIV_W-1:0] dvd;
    logic             div_done;
    logic [DIV_W-1:0] div_q;
    logic [7:0]       q_lvl;
    logic [3:0]       lv_idx;
    logic             grey;

    assign s_ready  = (state_reg == F_IDLE) && !hold;
    assign job_push = (state_reg == F_PUSH) && !job_full;

    always_comb begin
        job.cmd     = cmd_reg;
        job.channel = ch_reg;
        job.bin     = bin_reg;
        job.lv      = lv_reg;
        job.hue     = hue_reg;
    end

    // effective alpha, extremes and luma
    always_comb begin
        sel_prod  = alpha_reg * sel_reg;
        sel_sum   = 17'(sel_prod) + 17'd1 + 17'(sel_prod[15:8]);
        a_val     = selection_enable ? sel_sum[15:8] : alpha_reg;
        mx_val    = r_reg;
        which_val = 2'd0;
        if (mx_val < g_reg) begin
            mx_val    = g_reg;
            which_val = 2'd1;
        end
        if (mx_val < b_reg) begin
            mx_val    = b_reg;
            which_val = 2'd2;
        end
        mn_val = r_reg;
        if (mn_val > g_reg) mn_val = g_reg;
        if (mn_val > b_reg) mn_val = b_reg;
        luma_sum = W_RED * 24'(r_reg) + W_GREEN * 24'(g_reg) + W_BLUE * 24'(b_reg);
    end

    // hue numerator
    always_comb begin
        d_s = $signed({12'd0, d_reg});
        case (which_reg)
            2'd0: begin
                diff_s = $signed({12'd0, g_reg}) - $signed({12'd0, b_reg});
                base_s = '0;
            end
            2'd1: begin
                diff_s = $signed({12'd0, b_reg}) - $signed({12'd0, r_reg});
                base_s = d_s * 20'sd120;
            end
            default: begin
                diff_s = $signed({12'd0, r_reg}) - $signed({12'd0, g_reg});
                base_s = d_s * 20'sd240;
            end
        endcase
        num_s = base_s + diff_s * 20'sd60;
        if (num_s < 0) num_s = num_s + d_s * 20'sd360;
        grey = (r_reg == g_reg) && (r_reg == b_reg);
    end

    // divider operands
    always_comb begin
        case (op_reg)
            OP_RED:   x_val = r_reg;
            OP_GREEN: x_val = g_reg;
            OP_BLUE:  x_val = b_reg;
            OP_LUMA:  x_val = luma_reg;
            OP_CYAN:  x_val = c_reg;
            OP_MAG:   x_val = m_reg;
            OP_YEL:   x_val = y_reg;
            default:  x_val = k_reg;
        endcase
        case (op_reg)
            OP_SAT: begin
                dvd = DIV_W'({d_reg, 8'd0} - {8'd0, d_reg});
                dvs = mx_reg;
            end
            OP_HUE: begin
                dvd = num_reg;
                dvs = d_reg;
            end
            default: begin
                dvd = DIV_W'({x_val, 8'd0} - {8'd0, x_val});
                dvs = a_reg;
            end
        endcase
        q_lvl  = (div_q > DIV_W'(255)) ? 8'd255 : div_q[7:0];
        lv_idx = (op_reg < OP_SAT) ? op_reg : op_reg + 4'd1;
    end

    lch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == F_START),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (s_valid && s_ready) begin
                state_next = (cmd_t'(s_cmd) == CMD_COUNT) ? F_PREP1 : F_PUSH;
            end
            F_PREP1: state_next = F_PREP2;
            F_PREP2: state_next = (a_reg == '0) ? F_IDLE : F_START;
            F_START: state_next = F_WAIT;
            F_WAIT:  if (div_done) begin
                state_next = (op_reg == OP_HUE) ? F_PUSH : F_START;
            end
            F_PUSH:  if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid && s_ready) begin
            cmd_reg   <= cmd_t'(s_cmd);
            ch_reg    <= s_channel;
            bin_reg   <= s_bin;
            r_reg     <= s_red;
            g_reg     <= s_green;
            b_reg     <= s_blue;
            alpha_reg <= s_alpha;
            sel_reg   <= s_selection;
        end
        if (state_reg == F_PREP1) begin
            a_reg     <= a_val;
            mx_reg    <= mx_val;
            mn_reg    <= mn_val;
            which_reg <= which_val;
            d_reg     <= mx_val - mn_val;
            luma_reg  <= luma_sum[23:16];
        end
        if (state_reg == F_PREP2) begin
            num_reg          <= num_s[DIV_W-1:0];
            lv_reg[LV_ALPHA] <= a_reg;
            op_reg           <= OP_RED;
            if (grey) begin
                k_reg <= 8'd255 - r_reg;
                c_reg <= '0;
                m_reg <= '0;
                y_reg <= '0;
            end else begin
                k_reg <= mn_reg;
                c_reg <= 8'd255 - r_reg;
                m_reg <= 8'd255 - g_reg;
                y_reg <= 8'd255 - b_reg;
            end
        end
        if (state_reg == F_WAIT && div_done) begin
            op_reg <= op_reg + 4'd1;
            if (op_reg == OP_HUE) begin
                if (d_reg == '0) begin
                    hue_reg <= '0;
                end else if (div_q >= DIV_W'(HUE_BINS)) begin
                    hue_reg <= HUE_AW'(HUE_BINS - 1);
                end else begin
                    hue_reg <= div_q[HUE_AW-1:0];
                end
            end else if (op_reg == OP_SAT) begin
                lv_reg[lv_idx] <= (mx_reg == '0) ? 8'd0 : q_lvl;
            end else begin
                lv_reg[lv_idx] <= q_lvl;
            end
        end
    end
endmodule

`default_nettype wire

FILE: rtl/lch_queue.sv
// ----------------------------------------------------------------------------
// lch_queue
// two entry job queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module lch_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lch_pkg::lch_job_t din,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output lch_pkg::lch_job_t      dout
);
    import lch_pkg::*;

    lch_job_t   slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign dout      = slot_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= din;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/lch_back.sv
// ----------------------------------------------------------------------------
// lch_back
// bin memories, channel extents, clearing pass and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lch_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    input  wire lch_pkg::lch_job_t job,
    output logic                   job_pop,
    output logic                   init_busy,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [23:0]            m_count,
    output logic [7:0]             m_lowest_bin,
    output logic [7:0]             m_highest_bin,
    output logic                   m_channel_empty
);
    import lch_pkg::*;

    typedef enum logic [7:0] {
        B_INIT     = 8'b00000001,
        B_IDLE     = 8'b00000010,
        B_CLEAR    = 8'b00000100,
        B_CNT_RD   = 8'b00001000,
        B_CNT_WR   = 8'b00010000,
        B_BIN_RD   = 8'b00100000,
        B_BIN_DATA = 8'b01000000,
        B_OUT      = 8'b10000000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [LEVEL_AW-1:0]      clr_reg;
    logic [3:0]               step_reg;
    logic [LEVEL_CH-1:0]      seen_reg;
    logic [LEVEL_CH-1:0][7:0] low_reg, high_reg;
    logic [COUNT_W-1:0]       res_count_reg;
    logic [7:0]               res_low_reg, res_high_reg;
    logic                     res_empty_reg;
    logic                     hue_hit_reg, lvl_hit_reg;
    logic                     m_valid_reg;
    logic [23:0]              m_count_reg;
    logic [7:0]               m_low_reg, m_high_reg;
    logic                     m_empty_reg;

    logic                lvl_we, lvl_re, hue_we, hue_re;
    logic [LEVEL_AW-1:0] lvl_waddr, lvl_raddr, lvl_caddr;
    logic [HUE_AW-1:0]   hue_waddr, hue_raddr;
    logic [COUNT_W-1:0]  lvl_wdata, hue_wdata, lvl_rdata, hue_rdata;
    logic                lvl_ok;
    logic [3:0]          lvl_idx;
    logic                clr_last, out_free;
    logic [7:0]          ext_low, ext_high;
    logic                ext_empty;

    assign init_busy       = state_reg == B_INIT;
    assign clr_last        = clr_reg == LEVEL_AW'(LEVEL_DEPTH - 1);
    assign out_free        = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_count         = m_count_reg;
    assign m_lowest_bin    = m_low_reg;
    assign m_highest_bin   = m_high_reg;
    assign m_channel_empty = m_empty_reg;
    assign lvl_caddr       = {step_reg, job.lv[step_reg]};

    always_comb begin
        lvl_ok  = (job.channel < CH_HUE) ||
                  ((job.channel > CH_HUE) && (job.channel <= CH_LAST));
        lvl_idx = (job.channel < CH_HUE) ? job.channel : job.channel - 4'd1;
        ext_low   = '0;
        ext_high  = '0;
        ext_empty = 1'b1;
        if (job.channel == CH_HUE) begin
            ext_empty = !seen_reg[LV_ALPHA];
        end else if (lvl_ok && seen_reg[lvl_idx]) begin
            ext_low   = low_reg[lvl_idx];
            ext_high  = high_reg[lvl_idx];
            ext_empty = 1'b0;
        end
    end

    always_comb begin
        lvl_we    = 1'b0;
        lvl_waddr = clr_reg;
        lvl_wdata = '0;
        hue_we    = 1'b0;
        hue_waddr = clr_reg[HUE_AW-1:0];
        hue_wdata = '0;
        lvl_re    = 1'b0;
        lvl_raddr = lvl_caddr;
        hue_re    = 1'b0;
        hue_raddr = job.hue;
        case (state_reg)
            B_INIT, B_CLEAR: begin
                lvl_we = 1'b1;
                hue_we = clr_reg < LEVEL_AW'(HUE_BINS);
            end
            B_CNT_RD: begin
                lvl_re = step_reg <= LV_LAST;
                hue_re = step_reg > LV_LAST;
            end
            B_CNT_WR: begin
                lvl_we    = step_reg <= LV_LAST;
                lvl_waddr = lvl_caddr;
                lvl_wdata = sat_inc(lvl_rdata);
                hue_we    = step_reg > LV_LAST;
                hue_waddr = job.hue;
                hue_wdata = sat_inc(hue_rdata);
            end
            B_BIN_RD: begin
                lvl_raddr = {lvl_idx, job.bin[7:0]};
                hue_raddr = job.bin[HUE_AW-1:0];
                lvl_re    = lvl_ok && (job.bin < 9'(LEVEL_BINS));
                hue_re    = (job.channel == CH_HUE) && (job.bin < 9'(HUE_BINS));
            end
            default: ;
        endcase
    end

    lch_ram #(.WIDTH(COUNT_W), .DEPTH(LEVEL_DEPTH)) u_level_ram (
        .aclk  (aclk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .re    (lvl_re),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    lch_ram #(.WIDTH(COUNT_W), .DEPTH(HUE_BINS)) u_hue_ram (
        .aclk  (aclk),
        .we    (hue_we),
        .waddr (hue_waddr),
        .wdata (hue_wdata),
        .re    (hue_re),
        .raddr (hue_raddr),
        .rdata (hue_rdata)
    );

    always_comb begin
        state_next = state_reg;
        job_pop    = 1'b0;
        unique case (state_reg)
            B_INIT: if (clr_last) state_next = B_IDLE;
            B_IDLE: if (job_valid) begin
                case (job.cmd)
                    CMD_COUNT:    state_next = B_CNT_RD;
                    CMD_CLEAR:    state_next = B_CLEAR;
                    CMD_READ_BIN: state_next = B_BIN_RD;
                    default:      state_next = B_OUT;
                endcase
            end
            B_CLEAR: if (clr_last) begin
                state_next = B_IDLE;
                job_pop    = 1'b1;
            end
            B_CNT_RD: state_next = B_CNT_WR;
            B_CNT_WR: if (step_reg > LV_LAST) begin
                state_next = B_IDLE;
                job_pop    = 1'b1;
            end else begin
                state_next = B_CNT_RD;
            end
            B_BIN_RD:   state_next = B_BIN_DATA;
            B_BIN_DATA: state_next = B_OUT;
            B_OUT: if (out_free) begin
                state_next = B_IDLE;
                job_pop    = 1'b1;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_INIT;
            clr_reg     <= '0;
            step_reg    <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_INIT || state_reg == B_CLEAR) begin
                clr_reg <= clr_last ? '0 : clr_reg + 1'b1;
            end
            if (state_reg == B_IDLE && job_valid) begin
                step_reg <= '0;
                if (job.cmd == CMD_CLEAR) seen_reg <= '0;
            end
            if (state_reg == B_CNT_WR) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg > LV_LAST) begin
                    for (int i = 0; i < LEVEL_CH; i++) begin
                        seen_reg[i] <= 1'b1;
                    end
                end
            end
            if (state_reg == B_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_CNT_WR && step_reg > LV_LAST) begin
            for (int i = 0; i < LEVEL_CH; i++) begin
                if (!seen_reg[i]) begin
                    low_reg[i]  <= job.lv[i];
                    high_reg[i] <= job.lv[i];
                end else begin
                    if (job.lv[i] < low_reg[i])  low_reg[i]  <= job.lv[i];
                    if (job.lv[i] > high_reg[i]) high_reg[i] <= job.lv[i];
                end
            end
        end
        if (state_reg == B_BIN_RD) begin
            hue_hit_reg <= hue_re;
            lvl_hit_reg <= lvl_re;
        end
        if (state_reg == B_IDLE && job_valid) begin
            res_count_reg <= '0;
            res_low_reg   <= ext_low;
            res_high_reg  <= ext_high;
            res_empty_reg <= ext_empty;
        end
        if (state_reg == B_BIN_DATA) begin
            res_low_reg   <= '0;
            res_high_reg  <= '0;
            res_empty_reg <= 1'b0;
            res_count_reg <= hue_hit_reg ? hue_rdata : lvl_hit_reg ? lvl_rdata : '0;
        end
        if (state_reg == B_OUT && out_free) begin
            m_count_reg <= 24'(res_count_reg);
            m_low_reg   <= res_low_reg;
            m_high_reg  <= res_high_reg;
            m_empty_reg <= res_empty_reg;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/layer_color_histogram_top.sv
// ----------------------------------------------------------------------------
// layer_color_histogram_top
// rgba, hue, saturation, luma and cmyk histograms of a premultiplied pixel stream
// ----------------------------------------------------------------------------
// count pixel: ten divisions in turn on one shared divider in the front end, then a
//   read-modify-write of each of the eleven bins on the bin rams
// read bin: B_BIN_RD, B_BIN_DATA, B_OUT; read extents: B_OUT; from queue head to result register
// clear command and reset: clearing pass over all 2560 level bins and the hue bins, input
//   not ready during the pass after reset; selection_enable resets to 0
// ----------------------------------------------------------------------------
`default_nettype none

module layer_color_histogram_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    input  wire logic [7:0]  s_alpha,
    input  wire logic [7:0]  s_selection,
    input  wire logic [3:0]  s_channel,
    input  wire logic [8:0]  s_bin,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_count,
    output logic [7:0]       m_lowest_bin,
    output logic [7:0]       m_highest_bin,
    output logic             m_channel_empty
);
    import lch_pkg::*;

    logic     sel_en_reg;
    logic     init_busy;
    logic     q_push, q_full, q_pop, q_valid;
    lch_job_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            sel_en_reg <= cfg_data;
        end
    end

    lch_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .selection_enable (sel_en_reg),
        .hold             (init_busy),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_red            (s_red),
        .s_green          (s_green),
        .s_blue           (s_blue),
        .s_alpha          (s_alpha),
        .s_selection      (s_selection),
        .s_channel        (s_channel),
        .s_bin            (s_bin),
        .job_push         (q_push),
        .job_full         (q_full),
        .job              (q_in)
    );

    lch_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (q_out)
    );

    lch_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (q_valid),
        .job             (q_out),
        .job_pop         (q_pop),
        .init_busy       (init_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_count         (m_count),
        .m_lowest_bin    (m_lowest_bin),
        .m_highest_bin   (m_highest_bin),
        .m_channel_empty (m_channel_empty)
    );
endmodule

`default_nettype wire
